// File: src/tsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants for the tagged slot ring router
// Field widths, action and status codes, and default build parameters.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int ACT_W  = 3;
  localparam int TAG_W  = 32;
  localparam int MSG_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(16);

  localparam logic [ACT_W-1:0] ACT_OPEN     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DROP_OLD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DROP_NEW = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ROUTE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd3;

endpackage

// File: src/tsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tsr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_unit: shared ring pointer step and tag compare
// Steps a slot index forward or back around a ring of n slots and compares
// a stored tag against the search tag.
// ----------------------------------------------------------------------------
module tsr_unit #(
  parameter int SLOTS = tsr_pkg::SLOTS_DEF
) (
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  logic                     back,
  input  logic [tsr_pkg::CNT_W-1:0] ring_n,
  input  logic [tsr_pkg::TAG_W-1:0] tag_a,
  input  logic [tsr_pkg::TAG_W-1:0] tag_b,
  output logic [$clog2(SLOTS)-1:0] idx_next,
  output logic                     tag_eq
);
  import tsr_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int PW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  logic [PW-1:0] idx_w;
  logic [PW-1:0] n_w;
  logic [PW-1:0] inc_w;
  logic [PW-1:0] res_w;

  assign idx_w = {{(PW-IDX_W){1'b0}}, idx};
  assign n_w   = PW'(ring_n);
  assign inc_w = idx_w + PW'(1);

  always_comb begin
    if (back) begin
      res_w = (idx_w == '0 || idx_w >= n_w) ? n_w - PW'(1) : idx_w - PW'(1);
    end else begin
      res_w = (inc_w >= n_w) ? '0 : inc_w;
    end
  end

  assign idx_next = res_w[IDX_W-1:0];
  assign tag_eq   = (tag_a == tag_b);

endmodule

// File: src/tagged_slot_ring_router.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_slot_ring_router: deque of tagged slots with routing by tag
// Timing: every action but route strobes its result in the cycle after start.
// Route compares k slots in the search state, one tag memory read and compare
// per cycle, then strobes. busy is high until the result strobes; the next item
// can start in the cycle the result is shown. Results cannot be stalled.
// Reset (synchronous, rst_n low) empties the ring and sets slot_count to 16.
// ----------------------------------------------------------------------------
module tagged_slot_ring_router #(
  parameter int SLOTS = tsr_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [tsr_pkg::ACT_W-1:0]    in_action,
  input  logic [tsr_pkg::TAG_W-1:0]    in_tag,
  input  logic [tsr_pkg::MSG_W-1:0]    in_message_id,
  output logic                         out_valid,
  output logic [tsr_pkg::STAT_W-1:0]   out_status,
  output logic [tsr_pkg::SLOT_W-1:0]   out_slot,
  output logic [tsr_pkg::MSG_W-1:0]    out_message_id_res,
  output logic [tsr_pkg::CNT_W-1:0]    out_fill,
  input  logic                         cfg_we,
  input  logic [tsr_pkg::CNT_W-1:0]    cfg_wdata
);
  import tsr_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int PW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int NW    = ($clog2(SLOTS + 1) > CNT_W) ? $clog2(SLOTS + 1) : CNT_W;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [CNT_W-1:0]   slot_count_r, slot_count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [MSG_W-1:0]   msg_r, msg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [MSG_W-1:0]   out_msg_r, out_msg_nxt;
  logic [CNT_W-1:0]   out_fill_r, out_fill_nxt;

  logic [NW-1:0]      cnt_wide;
  logic [NW-1:0]      n_wide;
  logic [CNT_W-1:0]   ring_n;

  logic [IDX_W-1:0]   u_idx;
  logic               u_back;
  logic [IDX_W-1:0]   u_next;
  logic               u_eq;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [TAG_W-1:0]   ram_rdata;
  logic               accept;
  logic [PW-1:0]      slot_w;

  // effective ring size: slot_count clamped to 1..SLOTS
  assign cnt_wide = NW'(slot_count_r);
  always_comb begin
    if (cnt_wide == '0) begin
      n_wide = NW'(1);
    end else if (cnt_wide > NW'(SLOTS)) begin
      n_wide = NW'(SLOTS);
    end else begin
      n_wide = cnt_wide;
    end
  end
  assign ring_n = n_wide[CNT_W-1:0];

  assign accept = start && (state_r == S_IDLE);

  // shared unit input select
  always_comb begin
    u_idx  = head_r;
    u_back = 1'b0;
    if (state_r == S_SEARCH) begin
      u_idx = idx_r;
    end else if (in_action == ACT_DROP_NEW) begin
      u_idx  = tail_r;
      u_back = 1'b1;
    end else if (in_action == ACT_OPEN) begin
      u_idx = tail_r;
    end
  end

  tsr_unit #(.SLOTS(SLOTS)) u_unit (
    .idx      (u_idx),
    .back     (u_back),
    .ring_n   (ring_n),
    .tag_a    (ram_rdata),
    .tag_b    (tag_r),
    .idx_next (u_next),
    .tag_eq   (u_eq)
  );

  // only live slots are ever read, and each was written when opened,
  // so the tag store needs no clearing
  assign ram_we    = accept && !cfg_we && (in_action == ACT_OPEN) && (live_r < ring_n);
  assign ram_waddr = tail_r;
  assign ram_raddr = (state_r == S_SEARCH) ? u_next : head_r;

  tsr_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tag),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    live_nxt       = live_r;
    slot_count_nxt = slot_count_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    tag_nxt        = tag_r;
    msg_nxt        = msg_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_msg_nxt    = out_msg_r;
    out_fill_nxt   = out_fill_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // resizing empties the ring
          slot_count_nxt = cfg_wdata;
          head_nxt       = '0;
          tail_nxt       = '0;
          live_nxt       = '0;
        end else if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = '0;
          out_msg_nxt    = '0;
          out_fill_nxt   = live_r;
          case (in_action)
            ACT_OPEN: begin
              if (live_r >= ring_n) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_idx_nxt  = tail_r;
                tail_nxt     = u_next;
                live_nxt     = live_r + CNT_W'(1);
                out_fill_nxt = live_r + CNT_W'(1);
              end
            end
            ACT_DROP_OLD: begin
              if (live_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_idx_nxt  = head_r;
                head_nxt     = u_next;
                live_nxt     = live_r - CNT_W'(1);
                out_fill_nxt = live_r - CNT_W'(1);
              end
            end
            ACT_DROP_NEW: begin
              if (live_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_idx_nxt  = u_next;
                tail_nxt     = u_next;
                live_nxt     = live_r - CNT_W'(1);
                out_fill_nxt = live_r - CNT_W'(1);
              end
            end
            ACT_ROUTE: begin
              out_msg_nxt = in_message_id;
              if (live_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // head read is in flight; result comes from the search
                out_valid_nxt = 1'b0;
                idx_nxt       = head_r;
                cnt_nxt       = '0;
                tag_nxt       = in_tag;
                msg_nxt       = in_message_id;
                state_nxt     = S_SEARCH;
              end
            end
            ACT_QUERY: begin
              if (live_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                out_idx_nxt = head_r;
              end
            end
            ACT_CLEAR: begin
              head_nxt     = '0;
              tail_nxt     = '0;
              live_nxt     = '0;
              out_fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // ram_rdata holds the tag of slot idx_r
        if (u_eq) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = idx_r;
          out_msg_nxt    = msg_r;
          out_fill_nxt   = live_r;
          state_nxt      = S_IDLE;
        end else if (cnt_r + CNT_W'(1) == live_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_MATCH;
          out_idx_nxt    = '0;
          out_msg_nxt    = msg_r;
          out_fill_nxt   = live_r;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = u_next;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      live_r       <= '0;
      slot_count_r <= SLOT_COUNT_RST;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      live_r       <= live_nxt;
      slot_count_r <= slot_count_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    tag_r        <= tag_nxt;
    msg_r        <= msg_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_msg_r    <= out_msg_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign slot_w = {{(PW-IDX_W){1'b0}}, out_idx_r};

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = slot_w[SLOT_W-1:0];
  assign out_message_id_res = out_msg_r;
  assign out_fill           = out_fill_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for tagged_slot_ring_router
// Predicts every result from a local model of the slot ring (tags, head, tail,
// live count, size register), checks every strobed result field by field,
// and sweeps ring sizes including out-of-range values with random traffic.
// ----------------------------------------------------------------------------
module tb;
  import tsr_pkg::*;

  // actions the block does not define; they change nothing and return OK
  localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;

  typedef enum logic [1:0] {REQ_OP, REQ_CFG, REQ_DRAIN} req_kind_t;

  typedef struct packed {
    req_kind_t          kind;
    logic [ACT_W-1:0]   act;
    logic [TAG_W-1:0]   tag;
    logic [MSG_W-1:0]   mid;
    logic [CNT_W-1:0]   cfg;
    logic [3:0]         gap;
  } ring_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [MSG_W-1:0]   mid;
    logic [CNT_W-1:0]   fill;
  } ring_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ACT_W-1:0]    in_action = '0;
  logic [TAG_W-1:0]    in_tag = '0;
  logic [MSG_W-1:0]    in_message_id = '0;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [MSG_W-1:0]    out_message_id_res;
  logic [CNT_W-1:0]    out_fill;
  logic                cfg_we = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  tagged_slot_ring_router uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_tag             (in_tag),
    .in_message_id      (in_message_id),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_message_id_res (out_message_id_res),
    .out_fill           (out_fill),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------- ring model ----------------
  logic [TAG_W-1:0]  tag_mem [SLOTS_DEF];
  int                head_ptr;
  int                tail_ptr;
  int                live_n;
  logic [CNT_W-1:0]  size_reg;

  ring_req_t         op_q[$];
  ring_result_t      outcome_q[$];
  int                err_cnt = 0;
  bit                no_idle = 1'b0;

  function automatic int ring_len();
    int n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > SLOTS_DEF) n = SLOTS_DEF;
    return n;
  endfunction

  function automatic int ring_next(int i, int n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  function automatic int ring_prev(int i, int n);
    return (i == 0 || i >= n) ? n - 1 : i - 1;
  endfunction

  function automatic void ring_flush();
    for (int i = 0; i < SLOTS_DEF; i++) tag_mem[i] = '0;
    head_ptr = 0;
    tail_ptr = 0;
    live_n = 0;
  endfunction

  function automatic void ring_resize(logic [CNT_W-1:0] v);
    size_reg = v;
    ring_flush();
  endfunction

  function automatic ring_result_t ring_outcome(logic [ACT_W-1:0] act,
                                                logic [TAG_W-1:0] tag,
                                                logic [MSG_W-1:0] mid);
    ring_result_t r;
    int n;
    int idx;
    bit hit;
    r = '0;
    n = ring_len();
    case (act)
      ACT_OPEN: begin
        if (live_n >= n) begin
          r.status = ST_FULL;
        end else begin
          r.slot = SLOT_W'(tail_ptr);
          tag_mem[tail_ptr] = tag;
          tail_ptr = ring_next(tail_ptr, n);
          live_n++;
        end
      end
      ACT_DROP_OLD: begin
        if (live_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.slot = SLOT_W'(head_ptr);
          tag_mem[head_ptr] = '0;
          head_ptr = ring_next(head_ptr, n);
          live_n--;
        end
      end
      ACT_DROP_NEW: begin
        if (live_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // step back first, then free the newest slot
          tail_ptr = ring_prev(tail_ptr, n);
          r.slot = SLOT_W'(tail_ptr);
          tag_mem[tail_ptr] = '0;
          live_n--;
        end
      end
      ACT_ROUTE: begin
        r.mid = mid;
        if (live_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = 1'b0;
          idx = head_ptr;
          for (int k = 0; k < live_n && !hit; k++) begin
            if (tag_mem[idx] == tag) begin
              hit = 1'b1;
              r.slot = SLOT_W'(idx);
            end else begin
              idx = ring_next(idx, n);
            end
          end
          if (!hit) r.status = ST_NO_MATCH;
        end
      end
      ACT_QUERY: begin
        if (live_n == 0) r.status = ST_EMPTY;
        else r.slot = SLOT_W'(head_ptr);
      end
      ACT_CLEAR: ring_flush();
      default: ;
    endcase
    r.fill = CNT_W'(live_n);
    return r;
  endfunction

  // ---------------- driver ----------------
  ring_req_t  head_req;
  logic       drv_go;
  logic       drv_we;
  bit         gap_armed = 1'b0;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      drv_go = start;
      drv_we = 1'b0;
      if (cfg_we) ring_resize(cfg_wdata);
      if (start && !busy) begin
        outcome_q.push_back(ring_outcome(in_action, in_tag, in_message_id));
        drv_go = 1'b0;
      end
      if (!drv_go && !cfg_we && op_q.size() != 0) begin
        head_req = op_q[0];
        case (head_req.kind)
          REQ_OP: begin
            if (!gap_armed) begin
              gap_left = head_req.gap;
              gap_armed = 1'b1;
            end
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              in_action <= head_req.act;
              in_tag <= head_req.tag;
              in_message_id <= head_req.mid;
              drv_go = 1'b1;
              gap_armed = 1'b0;
              void'(op_q.pop_front());
            end
          end
          REQ_CFG: begin
            // size writes only with nothing in flight
            if (outcome_q.size() == 0) begin
              cfg_wdata <= head_req.cfg;
              drv_we = 1'b1;
              void'(op_q.pop_front());
            end
          end
          default: begin
            if (outcome_q.size() == 0) void'(op_q.pop_front());
          end
        endcase
      end
      start <= drv_go;
      cfg_we <= drv_we;
    end
  end

  // ---------------- monitor ----------------
  ring_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: status %0d slot %0d msg %h fill %0d", $time,
                 out_status, out_slot, out_message_id_res, out_fill);
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.status || out_slot !== want.slot ||
            out_message_id_res !== want.mid || out_fill !== want.fill) begin
          err_cnt++;
          $display("%0t: mismatch: expected status %0d slot %0d msg %h fill %0d,",
                   $time, want.status, want.slot, want.mid, want.fill);
          $display("%0t:           got status %0d slot %0d msg %h fill %0d",
                   $time, out_status, out_slot, out_message_id_res, out_fill);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void push_op(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag,
                                  logic [MSG_W-1:0] mid);
    ring_req_t q;
    q = '0;
    q.kind = REQ_OP;
    q.act = act;
    q.tag = tag;
    q.mid = mid;
    q.gap = no_idle ? 4'd0 : 4'($urandom_range(0, 12));
    op_q.push_back(q);
  endfunction

  function automatic void push_cfg(logic [CNT_W-1:0] v);
    ring_req_t q;
    q = '0;
    q.kind = REQ_CFG;
    q.cfg = v;
    op_q.push_back(q);
  endfunction

  function automatic void push_drain();
    ring_req_t q;
    q = '0;
    q.kind = REQ_DRAIN;
    op_q.push_back(q);
  endfunction

  initial begin
    logic [TAG_W-1:0]  tag_pool [6];
    logic [TAG_W-1:0]  ptag;
    logic [ACT_W-1:0]  act;
    logic [CNT_W-1:0]  sz;
    int                open_pct;
    int                pick;

    ring_resize(SLOT_COUNT_RST);

    // directed: empty ring, extremes of tag and handle, duplicate tags
    push_op(ACT_QUERY, 32'h0, 16'h0);
    push_op(ACT_DROP_OLD, 32'h0, 16'h0);
    push_op(ACT_DROP_NEW, 32'hFFFF_FFFF, 16'hFFFF);
    push_op(ACT_ROUTE, 32'h0, 16'hFFFF);
    push_op(ACT_OPEN, 32'h0, 16'h0);
    push_op(ACT_OPEN, 32'hFFFF_FFFF, 16'h0);
    push_op(ACT_OPEN, 32'h1234_5678, 16'h0);
    push_op(ACT_OPEN, 32'hFFFF_FFFF, 16'h0);
    push_op(ACT_ROUTE, 32'hFFFF_FFFF, 16'h0);
    push_op(ACT_ROUTE, 32'h0, 16'h5A5A);
    push_op(ACT_ROUTE, 32'hDEAD_BEEF, 16'hA5A5);
    push_op(ACT_QUERY, 32'h0, 16'h0);
    push_op(ACT_DROP_NEW, 32'h0, 16'h0);
    push_op(ACT_DROP_OLD, 32'h0, 16'h0);
    // freed slot holds zero but is not live
    push_op(ACT_ROUTE, 32'h0, 16'h1234);
    push_op(ACT_RSVD_A, 32'hFFFF_FFFF, 16'hFFFF);
    push_op(ACT_RSVD_B, 32'h0, 16'h0);
    push_op(ACT_CLEAR, 32'h0, 16'h0);
    push_drain();
    push_cfg(5'd1);
    push_op(ACT_OPEN, 32'hAAAA_5555, 16'h0);
    push_op(ACT_OPEN, 32'h5555_AAAA, 16'h0);
    push_op(ACT_ROUTE, 32'hAAAA_5555, 16'hBEEF);
    push_op(ACT_DROP_NEW, 32'h0, 16'h0);
    push_cfg(5'd2);
    push_op(ACT_OPEN, 32'h1, 16'h0);
    push_op(ACT_OPEN, 32'h2, 16'h0);
    push_op(ACT_ROUTE, 32'h2, 16'h0F0F);
    push_op(ACT_DROP_OLD, 32'h0, 16'h0);
    push_op(ACT_OPEN, 32'h3, 16'h0);
    push_op(ACT_DROP_NEW, 32'h0, 16'h0);

    // random phases, one ring size each
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: sz = 5'd1;
        1: sz = 5'd16;
        2: sz = 5'd0;
        3: sz = 5'd31;
        4: sz = 5'd2;
        5: sz = 5'd17;
        default: sz = 5'($urandom_range(0, 31));
      endcase
      push_cfg(sz);
      no_idle = (ph % 4 == 3);
      for (int j = 0; j < 6; j++) tag_pool[j] = $urandom;
      tag_pool[0] = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      open_pct = 50;
      for (int j = 0; j < 58; j++) begin
        // swing the fill level between nearly empty and full
        if (j % 20 == 0) open_pct = $urandom_range(25, 75);
        ptag = ($urandom_range(0, 9) != 0) ? tag_pool[$urandom_range(0, 5)] : $urandom;
        if ($urandom_range(0, 99) < open_pct) begin
          act = ACT_OPEN;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) act = ACT_ROUTE;
          else if (pick < 65) act = ACT_DROP_OLD;
          else if (pick < 82) act = ACT_DROP_NEW;
          else if (pick < 94) act = ACT_QUERY;
          else if (pick < 97) act = ACT_CLEAR;
          else act = $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
        end
        push_op(act, ptag, 16'($urandom));
        if ($urandom_range(0, 99) == 0) push_drain();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_q.size() != 0 || start || cfg_we || outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tagged_slot_ring_router verification clean");
    end else begin
      $display("tagged_slot_ring_router verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tagged_slot_ring_router verification failed");
    $finish;
  end

endmodule
